FILE: sv/rrts_pkg.sv
// ============================================================================
// rrts_pkg
// Shared types and constants of the round robin thread slot scheduler: the
// item and result structs, event and slot state codes, and the
// controller-to-datapath command and status structs.
// ============================================================================
package rrts_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_YIELD  = 3'd1;
    localparam logic [2:0] ACT_WAKE   = 3'd2;
    localparam logic [2:0] ACT_EXIT   = 3'd3;
    localparam logic [2:0] ACT_FIND   = 3'd4;

    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_RUNNING   = 3'd2;
    localparam logic [2:0] ST_WAITING   = 3'd3;
    localparam logic [2:0] ST_SUSPENDED = 3'd4;
    localparam logic [2:0] ST_EXITED    = 3'd5;

    localparam logic [31:0] ACTIVE_EXIT_CODE  = 32'd259;
    localparam logic [31:0] STACK_GAP         = 32'h0000_1000;
    localparam logic [31:0] SP_OFFSET         = 32'h0000_0100;
    localparam logic [31:0] ID_RESET          = 32'h0000_1000;
    localparam logic [31:0] HANDLE_RESET      = 32'h0000_7100;
    localparam logic [31:0] BASE_ADDR_RESET   = 32'h3000_0000;
    localparam logic [28:0] STACK_BYTES_RESET = 29'd1048576;

    typedef struct packed {
        logic [2:0]  action;
        logic        start_suspended;
        logic [2:0]  block_state;
        logic [31:0] wait_on;
        logic [31:0] target_handle;
        logic [31:0] exit_value;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [3:0]  slot;
        logic [31:0] thread_handle;
        logic [31:0] thread_id;
        logic [31:0] base_addr;
        logic [31:0] initial_sp;
        logic [2:0]  slot_state;
        logic [31:0] slot_exit_code;
        logic        current_valid;
        logic [3:0]  current_slot;
        logic [31:0] current_id;
        logic [31:0] created_count;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic setup;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: sv/round_robin_thread_slot_scheduler_core.sv
// ============================================================================
// round_robin_thread_slot_scheduler_core
// Thread slot table with create, yield, wake, exit and find events and
// round robin selection of the next ready slot.
// ============================================================================
// Usage: an event is presented on i_in_data with i_in_valid and is taken when
// o_in_stall is low. The block works on one event at a time and holds
// o_in_stall high until that event is committed. Every event scans all slots
// once, one slot per cycle through the registered read of the slot memories,
// before the next event can be taken. The result is loaded into an output
// register when the event is committed and is shown with o_out_valid until a
// transfer with i_out_stall low. While a result waits the next event may
// already be taken; it is committed only once the output register is free,
// so a stalling receiver holds the block in that event's final step. The user
// must write the stack size register through i_cfg_we and i_cfg_data only
// while no event is in progress; the block itself does not enforce this.
// Reset marks every slot free, clears the current thread and restores the
// id, handle and stack base counters; the block can take an event as soon
// as reset is released.
// ============================================================================
module round_robin_thread_slot_scheduler_core #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrts_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_we,
    input  logic [28:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrts_pkg::t_out_item o_out_data
);

    rrts_pkg::t_dp_cmd  w_cmd;
    rrts_pkg::t_dp_stat w_stat;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    rrts_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sv/rrts_ctrl.sv
// ============================================================================
// rrts_ctrl
// Sequencer of the scheduler: accepts one event, runs the setup step, the
// slot scan and its drain step, then commits the event and loads the result.
// ============================================================================
module rrts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output rrts_pkg::t_dp_cmd  o_cmd,
    input  rrts_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rrts_dpath.sv
// ============================================================================
// rrts_dpath
// Datapath of the scheduler: slot state flops, the per-slot id, handle,
// wait handle and exit code memories, the scan pipeline, the allocation
// counters and the result register.
// ============================================================================
module rrts_dpath #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrts_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_we,
    input  logic [28:0]         i_cfg_data,
    input  rrts_pkg::t_dp_cmd   i_cmd,
    output rrts_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrts_pkg::t_out_item o_out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    rrts_pkg::t_in_item  r_item;
    logic [28:0]         r_stack_bytes;
    logic [2:0]          r_state [SLOTS];

    logic [31:0]         m_id   [SLOTS];
    logic [31:0]         m_hnd  [SLOTS];
    logic [31:0]         m_wait [SLOTS];
    logic [31:0]         m_exit [SLOTS];

    logic                r_run_valid;
    logic [IW-1:0]       r_run_slot;
    logic [31:0]         r_cur_id;
    logic [31:0]         r_next_id;
    logic [31:0]         r_next_hnd;
    logic [31:0]         r_next_base;
    logic [31:0]         r_creations;

    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_cnt;
    logic [IW-1:0]       r_idx_q;
    logic                r_chk;
    logic                r_pick_en;
    logic [31:0]         r_rd_id;
    logic [31:0]         r_rd_hnd;
    logic [31:0]         r_rd_wait;
    logic [31:0]         r_rd_exit;

    logic                r_found;
    logic [IW-1:0]       r_found_idx;
    logic [31:0]         r_f_id;
    logic [31:0]         r_f_hnd;
    logic [2:0]          r_f_state;
    logic [31:0]         r_f_exit;

    logic                r_out_valid;
    rrts_pkg::t_out_item r_out;

    logic [IW-1:0]       w_idx_inc;
    logic [IW-1:0]       w_run_inc;
    logic [2:0]          w_clip;
    logic [2:0]          w_s;
    logic                w_hit;
    logic                w_wake;
    logic [31:0]         w_sp;
    logic [31:0]         w_base_next;
    logic                w_is_create;
    logic                w_is_yield;
    logic                w_is_exit;
    logic                w_create_we;
    logic                w_exit_we;
    logic [IW-1:0]       w_exit_addr;
    logic [31:0]         w_exit_data;
    logic                w_wait_we;

    rrts_pkg::t_out_item n_out;
    logic                n_run_valid;
    logic [IW-1:0]       n_run_slot;
    logic [31:0]         n_cur_id;
    logic [31:0]         n_creations;

    assign w_idx_inc   = (r_idx == LAST) ? '0 : r_idx + IW'(1);
    assign w_run_inc   = (r_run_slot == LAST) ? '0 : r_run_slot + IW'(1);
    assign w_clip      = (r_item.block_state > rrts_pkg::ST_EXITED) ?
                         rrts_pkg::ST_EXITED : r_item.block_state;
    assign w_sp        = r_next_base + 32'(r_stack_bytes) - rrts_pkg::SP_OFFSET;
    assign w_base_next = r_next_base + 32'(r_stack_bytes) + rrts_pkg::STACK_GAP;
    assign w_is_create = (r_item.action == rrts_pkg::ACT_CREATE);
    assign w_is_yield  = (r_item.action == rrts_pkg::ACT_YIELD);
    assign w_is_exit   = (r_item.action == rrts_pkg::ACT_EXIT);

    assign w_s = r_state[r_idx_q];

    always_comb begin
        w_hit = 1'b0;
        case (r_item.action)
            rrts_pkg::ACT_CREATE: w_hit = (w_s == rrts_pkg::ST_FREE);
            rrts_pkg::ACT_YIELD,
            rrts_pkg::ACT_EXIT:   w_hit = r_pick_en && (w_s == rrts_pkg::ST_READY);
            rrts_pkg::ACT_FIND:   w_hit = (w_s != rrts_pkg::ST_FREE) &&
                                          (r_rd_hnd == r_item.target_handle);
            default:              w_hit = 1'b0;
        endcase
    end

    assign w_wake = r_chk && (r_item.action == rrts_pkg::ACT_WAKE) &&
                    (w_s == rrts_pkg::ST_WAITING) &&
                    (r_rd_wait == r_item.target_handle);

    assign w_create_we = i_cmd.finish && w_is_create && r_found;
    assign w_wait_we   = i_cmd.setup && w_is_yield && r_run_valid;
    assign w_exit_we   = w_create_we || (i_cmd.setup && w_is_exit && r_run_valid);
    assign w_exit_addr = w_create_we ? r_found_idx : r_run_slot;
    assign w_exit_data = w_create_we ? rrts_pkg::ACTIVE_EXIT_CODE : r_item.exit_value;

    always_comb begin
        n_out       = '0;
        n_run_valid = r_run_valid;
        n_run_slot  = r_run_slot;
        n_cur_id    = r_cur_id;
        n_creations = r_creations;
        case (r_item.action)
            rrts_pkg::ACT_CREATE: begin
                if (r_found) begin
                    n_out.ok            = 1'b1;
                    n_out.slot          = 4'(r_found_idx);
                    n_out.thread_handle = r_next_hnd;
                    n_out.thread_id     = r_next_id;
                    n_out.base_addr     = r_next_base;
                    n_out.initial_sp    = w_sp;
                    n_creations         = r_creations + 32'd1;
                end
            end
            rrts_pkg::ACT_YIELD,
            rrts_pkg::ACT_EXIT: begin
                if (r_found) begin
                    n_out.ok    = w_is_yield;
                    n_run_valid = 1'b1;
                    n_run_slot  = r_found_idx;
                    n_cur_id    = r_f_id;
                end
            end
            rrts_pkg::ACT_FIND: begin
                if (r_found) begin
                    n_out.ok             = 1'b1;
                    n_out.slot           = 4'(r_found_idx);
                    n_out.thread_handle  = r_f_hnd;
                    n_out.thread_id      = r_f_id;
                    n_out.slot_state     = r_f_state;
                    n_out.slot_exit_code = r_f_exit;
                end
            end
            default: begin
            end
        endcase
        n_out.current_valid = n_run_valid;
        n_out.current_slot  = n_run_valid ? 4'(n_run_slot) : 4'd0;
        n_out.current_id    = n_run_valid ? n_cur_id : 32'd0;
        n_out.created_count = n_creations;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_bytes <= rrts_pkg::STACK_BYTES_RESET;
            for (int k = 0; k < SLOTS; k++) begin
                r_state[k] <= rrts_pkg::ST_FREE;
            end
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_next_id   <= rrts_pkg::ID_RESET;
            r_next_hnd  <= rrts_pkg::HANDLE_RESET;
            r_next_base <= rrts_pkg::BASE_ADDR_RESET;
            r_creations <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_chk       <= 1'b0;
            r_pick_en   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stack_bytes <= i_cfg_data;
            end

            r_chk <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_idx <= w_idx_inc;
                r_cnt <= r_cnt + IW'(1);
            end

            if (i_cmd.setup) begin
                r_found   <= 1'b0;
                r_cnt     <= '0;
                r_idx     <= '0;
                r_pick_en <= 1'b0;
                if (w_is_yield) begin
                    r_pick_en <= 1'b1;
                    if (r_run_valid) begin
                        r_state[r_run_slot] <= w_clip;
                        r_idx               <= w_run_inc;
                    end
                end else if (w_is_exit && r_run_valid) begin
                    r_pick_en           <= 1'b1;
                    r_state[r_run_slot] <= rrts_pkg::ST_EXITED;
                    r_run_valid         <= 1'b0;
                    r_run_slot          <= '0;
                end
            end

            if (r_chk && w_hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (w_wake) begin
                r_state[r_idx_q] <= rrts_pkg::ST_READY;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_run_valid <= n_run_valid;
                r_run_slot  <= n_run_slot;
                r_creations <= n_creations;
                if (w_create_we) begin
                    r_state[r_found_idx] <= r_item.start_suspended ?
                                            rrts_pkg::ST_SUSPENDED : rrts_pkg::ST_READY;
                    r_next_id   <= r_next_id + 32'd1;
                    r_next_hnd  <= r_next_hnd + 32'd1;
                    r_next_base <= w_base_next;
                end else if ((w_is_yield || w_is_exit) && r_found) begin
                    r_state[r_found_idx] <= rrts_pkg::ST_RUNNING;
                end else if (w_is_yield && r_run_valid) begin
                    r_state[r_run_slot] <= rrts_pkg::ST_RUNNING;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan) begin
            r_idx_q <= r_idx;
        end
        if (r_chk && w_hit && !r_found) begin
            r_found_idx <= r_idx_q;
            r_f_id      <= r_rd_id;
            r_f_hnd     <= r_rd_hnd;
            r_f_state   <= w_s;
            r_f_exit    <= r_rd_exit;
        end
        if (i_cmd.finish) begin
            r_cur_id <= n_cur_id;
            r_out    <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_create_we) begin
            m_id[r_found_idx]  <= r_next_id;
            m_hnd[r_found_idx] <= r_next_hnd;
        end
        if (w_exit_we) begin
            m_exit[w_exit_addr] <= w_exit_data;
        end
        if (w_wait_we) begin
            m_wait[r_run_slot] <= r_item.wait_on;
        end
        r_rd_id   <= m_id[r_idx];
        r_rd_hnd  <= m_hnd[r_idx];
        r_rd_wait <= m_wait[r_idx];
        r_rd_exit <= m_exit[r_idx];
    end

    assign o_stat.scan_last = (r_cnt == LAST);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

`ifndef NO_ASSERTIONS
    a_run_slot_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch && r_run_valid |-> r_state[r_run_slot] == rrts_pkg::ST_RUNNING)
        else $error("current slot is not in the running state between events");

    a_found_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(r_chk))
        else $error("match flag set outside the scan pipeline");

    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && w_is_create && r_found |=>
        r_creations == $past(r_creations) + 32'd1)
        else $error("creation counter did not advance on a successful create");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || !i_out_stall))
        else $error("result register loaded while holding an untaken result");
`endif

endmodule

FILE: tb/round_robin_thread_slot_scheduler_core_test.sv
// ============================================================================
// round_robin_thread_slot_scheduler_core_test
// Self-checking testbench for the thread slot scheduler. A queue of scheduling
// events (a short directed sequence, then random phases at several stack
// sizes) feeds a driver. Each accepted transfer updates a behavioral copy of
// the slot table and the predicted result is compared field by field with
// the block's output, under random idle and stall bursts and one long output
// hold-off that backs the block up.
// ============================================================================
`timescale 1ns / 100ps

module round_robin_thread_slot_scheduler_core_test;

    localparam int SLOT_COUNT = rrts_pkg::SLOTS_DEFAULT;
    localparam int PHASE_EVENTS = 350;
    localparam int LONG_HOLD = 300;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [2:0] BSTATE_UNDEF_LO = 3'd6;
    localparam logic [2:0] BSTATE_UNDEF_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    rrts_pkg::t_in_item  i_in_data = '0;
    logic                i_cfg_we = 1'b0;
    logic [28:0]         i_cfg_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rrts_pkg::t_out_item o_out_data;

    rrts_pkg::t_in_item  pending_events[$];
    rrts_pkg::t_out_item predicted_outcomes[$];
    int        mismatches = 0;
    bit        in_taken = 1'b0;
    bit        idling = 1'b1;
    bit        hold_wanted = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        stall_left = 0;
    int        send_gap = 0;
    int        sinks_left = 5;
    int        creates_issued = 0;

    logic [2:0]  slot_st[SLOT_COUNT];
    logic [31:0] slot_tid[SLOT_COUNT];
    logic [31:0] slot_hnd[SLOT_COUNT];
    logic [31:0] slot_wait[SLOT_COUNT];
    logic [31:0] slot_exit[SLOT_COUNT];
    bit          cur_ok = 1'b0;
    logic [3:0]  cur_slot = '0;
    logic [31:0] id_next = rrts_pkg::ID_RESET;
    logic [31:0] hnd_next = rrts_pkg::HANDLE_RESET;
    logic [31:0] base_next = rrts_pkg::BASE_ADDR_RESET;
    logic [31:0] n_created = '0;
    logic [28:0] cfg_stack_bytes = rrts_pkg::STACK_BYTES_RESET;

    round_robin_thread_slot_scheduler_core #(
        .SLOTS(SLOT_COUNT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit promote_ready(int from);
        int idx;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (from + k) % SLOT_COUNT;
            if (slot_st[idx] == rrts_pkg::ST_READY) begin
                cur_ok = 1'b1;
                cur_slot = 4'(idx);
                slot_st[idx] = rrts_pkg::ST_RUNNING;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rrts_pkg::t_out_item schedule_event(rrts_pkg::t_in_item ev);
        rrts_pkg::t_out_item r;
        bit        found;
        int        from;
        r = '0;
        found = 1'b0;
        from = 0;
        case (ev.action)
            rrts_pkg::ACT_CREATE: begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (!found && slot_st[k] == rrts_pkg::ST_FREE) begin
                        found = 1'b1;
                        r.ok = 1'b1;
                        r.slot = 4'(k);
                        r.thread_id = id_next;
                        r.thread_handle = hnd_next;
                        r.base_addr = base_next;
                        r.initial_sp = base_next + 32'(cfg_stack_bytes) - rrts_pkg::SP_OFFSET;
                        id_next = id_next + 1;
                        hnd_next = hnd_next + 1;
                        base_next = base_next + 32'(cfg_stack_bytes) + rrts_pkg::STACK_GAP;
                        slot_tid[k] = r.thread_id;
                        slot_hnd[k] = r.thread_handle;
                        slot_wait[k] = '0;
                        slot_exit[k] = rrts_pkg::ACTIVE_EXIT_CODE;
                        slot_st[k] = ev.start_suspended ? rrts_pkg::ST_SUSPENDED
                                                        : rrts_pkg::ST_READY;
                        n_created = n_created + 1;
                    end
                end
            end
            rrts_pkg::ACT_YIELD: begin
                if (cur_ok) begin
                    slot_st[cur_slot] = (ev.block_state > rrts_pkg::ST_EXITED)
                                        ? rrts_pkg::ST_EXITED : ev.block_state;
                    slot_wait[cur_slot] = ev.wait_on;
                    from = int'(cur_slot) + 1;
                end
                if (promote_ready(from)) begin
                    r.ok = 1'b1;
                end else if (cur_ok) begin
                    slot_st[cur_slot] = rrts_pkg::ST_RUNNING;
                end
            end
            rrts_pkg::ACT_WAKE: begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (slot_st[k] == rrts_pkg::ST_WAITING &&
                        slot_wait[k] == ev.target_handle) begin
                        slot_st[k] = rrts_pkg::ST_READY;
                        slot_wait[k] = '0;
                    end
                end
            end
            rrts_pkg::ACT_EXIT: begin
                if (cur_ok) begin
                    slot_st[cur_slot] = rrts_pkg::ST_EXITED;
                    slot_exit[cur_slot] = ev.exit_value;
                    cur_ok = 1'b0;
                    cur_slot = '0;
                    void'(promote_ready(0));
                end
            end
            rrts_pkg::ACT_FIND: begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (!found && slot_st[k] != rrts_pkg::ST_FREE &&
                        slot_hnd[k] == ev.target_handle) begin
                        found = 1'b1;
                        r.ok = 1'b1;
                        r.slot = 4'(k);
                        r.thread_handle = slot_hnd[k];
                        r.thread_id = slot_tid[k];
                        r.slot_state = slot_st[k];
                        r.slot_exit_code = slot_exit[k];
                    end
                end
            end
            default: begin
            end
        endcase
        r.current_valid = cur_ok;
        r.current_slot = cur_ok ? cur_slot : 4'd0;
        r.current_id = cur_ok ? slot_tid[cur_slot] : 32'd0;
        r.created_count = n_created;
        return r;
    endfunction

    function automatic rrts_pkg::t_in_item event_of(logic [2:0] action, logic susp,
                                                    logic [2:0] bstate,
                                                    logic [31:0] wait_on,
                                                    logic [31:0] target,
                                                    logic [31:0] exitv);
        rrts_pkg::t_in_item ev;
        ev.action = action;
        ev.start_suspended = susp;
        ev.block_state = bstate;
        ev.wait_on = wait_on;
        ev.target_handle = target;
        ev.exit_value = exitv;
        return ev;
    endfunction

    function automatic logic [31:0] wait_key();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return rrts_pkg::HANDLE_RESET + 32'd5;
            default: return 32'h5A5A_A5A5;
        endcase
    endfunction

    function automatic rrts_pkg::t_in_item draw_event();
        rrts_pkg::t_in_item ev;
        int       pick;
        ev = event_of(rrts_pkg::ACT_CREATE, 1'(($urandom_range(0, 1))),
                      3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
        if (sinks_left > 0 && $urandom_range(0, 199) == 0) begin
            sinks_left--;
            case ($urandom_range(0, 2))
                0: ev.action = rrts_pkg::ACT_EXIT;
                1: begin
                    ev.action = rrts_pkg::ACT_CREATE;
                    ev.start_suspended = 1'b1;
                end
                default: begin
                    ev.action = rrts_pkg::ACT_YIELD;
                    case ($urandom_range(0, 4))
                        0: ev.block_state = rrts_pkg::ST_RUNNING;
                        1: ev.block_state = rrts_pkg::ST_SUSPENDED;
                        2: ev.block_state = rrts_pkg::ST_EXITED;
                        3: ev.block_state = BSTATE_UNDEF_LO;
                        default: ev.block_state = BSTATE_UNDEF_HI;
                    endcase
                end
            endcase
            return ev;
        end
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            ev.action = rrts_pkg::ACT_CREATE;
            ev.start_suspended = 1'b0;
        end else if (pick < 62) begin
            ev.action = rrts_pkg::ACT_YIELD;
            pick = $urandom_range(0, 99);
            ev.block_state = (pick < 45) ? rrts_pkg::ST_READY :
                             (pick < 75) ? rrts_pkg::ST_WAITING : rrts_pkg::ST_FREE;
            ev.wait_on = wait_key();
        end else if (pick < 76) begin
            ev.action = rrts_pkg::ACT_WAKE;
            if ($urandom_range(0, 9) != 0) ev.target_handle = wait_key();
        end else if (pick < 94) begin
            ev.action = rrts_pkg::ACT_FIND;
            if ($urandom_range(0, 4) != 0) begin
                ev.target_handle = rrts_pkg::HANDLE_RESET + 32'(creates_issued)
                                   - $urandom_range(0, 24);
            end
        end else begin
            ev.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        return ev;
    endfunction

    task automatic queue_event(rrts_pkg::t_in_item ev);
        if (ev.action == rrts_pkg::ACT_CREATE) creates_issued++;
        pending_events.push_back(ev);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result(rrts_pkg::t_out_item got);
        rrts_pkg::t_out_item want;
        if (predicted_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
            want = predicted_outcomes.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("slot", want.slot, got.slot);
            compare_field("thread_handle", want.thread_handle, got.thread_handle);
            compare_field("thread_id", want.thread_id, got.thread_id);
            compare_field("base_addr", want.base_addr, got.base_addr);
            compare_field("initial_sp", want.initial_sp, got.initial_sp);
            compare_field("slot_state", want.slot_state, got.slot_state);
            compare_field("slot_exit_code", want.slot_exit_code, got.slot_exit_code);
            compare_field("current_valid", want.current_valid, got.current_valid);
            compare_field("current_slot", want.current_slot, got.current_slot);
            compare_field("current_id", want.current_id, got.current_id);
            compare_field("created_count", want.created_count, got.created_count);
        end
    endtask

    task automatic drain();
        while (pending_events.size() != 0 || i_in_valid || predicted_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SLOT_COUNT + 8) @(posedge i_clk);
    endtask

    task automatic set_stack_size(logic [28:0] bytes);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = bytes;
        cfg_stack_bytes = bytes;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) predicted_outcomes.push_back(schedule_event(i_in_data));
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 99) < 15) begin
                send_gap <= $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                i_in_data <= pending_events.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_wanted && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 99) < 12) begin
            stall_left <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        logic [28:0] sizes[5];
        bit          idle_of[5];
        sizes = '{29'd4096, 29'd268435456, 29'h1FFF_FFFF, 29'd0, rrts_pkg::STACK_BYTES_RESET};
        idle_of = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_st[k] = rrts_pkg::ST_FREE;
            slot_tid[k] = '0;
            slot_hnd[k] = '0;
            slot_wait[k] = '0;
            slot_exit[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, BSTATE_UNDEF_HI,
                             32'hFFFF_FFFF, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_EXIT, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'hFFFF_FFFF));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_CREATE, 1'b1, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_CREATE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, rrts_pkg::ST_READY,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, rrts_pkg::ST_SUSPENDED,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, BSTATE_UNDEF_HI,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_CREATE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, BSTATE_UNDEF_LO,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, rrts_pkg::HANDLE_RESET + 32'd1, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, rrts_pkg::HANDLE_RESET, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_CREATE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, rrts_pkg::ST_WAITING,
                             32'hFFFF_FFFF, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, rrts_pkg::HANDLE_RESET + 32'd2, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_WAKE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_WAKE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'hFFFF_FFFF, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_YIELD, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_CREATE, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_EXIT, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'hFFFF_FFFF));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, rrts_pkg::HANDLE_RESET + 32'd2, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_EXIT, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        queue_event(event_of(rrts_pkg::ACT_FIND, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'hFFFF_FFFF, 32'h0));
        queue_event(event_of(ACT_SPARE_HI, 1'b1, BSTATE_UNDEF_HI, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_event(event_of(ACT_SPARE_LO, 1'b0, rrts_pkg::ST_FREE,
                             32'h0, 32'h0, 32'h0));
        drain();

        for (int p = 0; p < 5; p++) begin
            set_stack_size(sizes[p]);
            idling = idle_of[p];
            if (p == 1) hold_wanted = 1'b1;
            for (int n = 0; n < PHASE_EVENTS; n++) queue_event(draw_event());
            drain();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
